### rtl/core/u2a_pkg.sv
package u2a_pkg;

	localparam logic [6:0]  REPL_RESET = 7'd63;
	localparam logic [20:0] CP_MAX     = 21'h10FFFF;
	localparam logic [20:0] SURR_LO    = 21'h00D800;
	localparam logic [20:0] SURR_HI    = 21'h00DFFF;
	localparam logic [20:0] MIN_2B     = 21'h000080;
	localparam logic [20:0] MIN_3B     = 21'h000800;
	localparam logic [20:0] MIN_4B     = 21'h010000;

	// controller -> datapath
	typedef struct packed {
		logic load;  // take the input beat into the byte window
		logic step;  // apply one decode step to the window
		logic pop;   // move one queued result into the output register
	} u2a_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       loop_done;  // window empty or rest must stay pending
		logic [2:0] ecnt;       // results queued for this beat
		logic       last_pop;   // next pop is the final queued result
		logic       out_free;   // output register can take a result
	} u2a_sts_t;

endpackage

### rtl/core/u2a_dp.sv
module u2a_dp
	import u2a_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [6:0]     cfg_wdata,
	input  logic [7:0]     in_byte,
	input  logic           in_eos,
	input  u2a_cmd_t       cmd,
	output u2a_sts_t       sts,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [6:0]     out_byte,
	output logic           out_run_last,
	output logic           out_done
);

	logic [6:0] repl_q;
	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic       eos_q;
	logic [6:0] emit_q [4];
	logic [2:0] ecnt_q;
	logic [1:0] rd_q;

	logic [2:0]  need;
	logic [3:0]  cont;
	logic        bad_cont;
	logic        fail;
	logic        stop;
	logic [2:0]  adv;
	logic [1:0]  nem;
	logic [6:0]  val;
	logic [20:0] cp;
	logic [20:0] minv;
	logic        pop_last;

	// lead byte class
	always_comb begin
		priority casez (buf_q[0])
			8'b0???????: need = 3'd1;
			8'b110?????: need = 3'd2;
			8'b1110????: need = 3'd3;
			8'b11110???: need = 3'd4;
			default:     need = 3'd0;
		endcase
	end

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cont[k] = (buf_q[k][7:6] == 2'b10);
		end
	end

	// a non-continuation inside the part of the sequence already seen
	always_comb begin
		bad_cont = 1'b0;
		for (int k = 1; k < 4; k++) begin
			if ((3'(k) < need) && (3'(k) < cnt_q) && !cont[k]) begin
				bad_cont = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (need)
			3'd2: begin
				cp   = {10'd0, buf_q[0][4:0], buf_q[1][5:0]};
				minv = MIN_2B;
			end
			3'd3: begin
				cp   = {5'd0, buf_q[0][3:0], buf_q[1][5:0], buf_q[2][5:0]};
				minv = MIN_3B;
			end
			default: begin
				cp   = {buf_q[0][2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
				minv = MIN_4B;
			end
		endcase
	end

	// one decode step on the head of the window
	always_comb begin
		stop = 1'b0;
		fail = 1'b0;
		adv  = 3'd0;
		nem  = 2'd0;
		val  = repl_q;
		if (need == 3'd1) begin
			adv = 3'd1;
			nem = 2'd1;
			val = buf_q[0][6:0];
		end else begin
			fail = (need == 3'd0) || bad_cont;
			if (!fail && (cnt_q < need)) begin
				if (eos_q) begin
					fail = 1'b1;
				end else begin
					stop = 1'b1;
				end
			end
			if (!fail && !stop) begin
				if ((cp < minv) || (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI))) begin
					fail = 1'b1;
				end else begin
					adv = need;
					nem = (need == 3'd4) ? 2'd2 : 2'd1;
				end
			end
			if (fail) begin
				adv = 3'd1;
				nem = 2'd1;
			end
		end
	end

	assign pop_last      = ({1'b0, rd_q} == (ecnt_q - 3'd1));
	assign sts.loop_done = (cnt_q == 3'd0) || stop;
	assign sts.ecnt      = ecnt_q;
	assign sts.last_pop  = pop_last;
	assign sts.out_free  = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q    <= REPL_RESET;
			cnt_q     <= 3'd0;
			ecnt_q    <= 3'd0;
			rd_q      <= 2'd0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				repl_q <= cfg_wdata;
			end
			if (cmd.load) begin
				cnt_q  <= cnt_q + 3'd1;
				ecnt_q <= 3'd0;
				rd_q   <= 2'd0;
			end else if (cmd.step) begin
				cnt_q  <= cnt_q - adv;
				ecnt_q <= ecnt_q + {1'b0, nem};
			end
			if (cmd.pop) begin
				out_valid <= 1'b1;
				rd_q      <= rd_q + 2'd1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// window, result queue and output payload: no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= in_byte;
			eos_q             <= in_eos;
		end else if (cmd.step) begin
			for (int i = 0; i < 4; i++) begin
				if ((i + int'(adv)) < 4) begin
					buf_q[i] <= buf_q[2'(i + int'(adv))];
				end
			end
			if (nem != 2'd0) begin
				emit_q[ecnt_q[1:0]] <= val;
			end
			if (nem == 2'd2) begin
				emit_q[ecnt_q[1:0] + 2'd1] <= val;
			end
		end
		if (cmd.pop) begin
			out_byte     <= emit_q[rd_q];
			out_run_last <= pop_last;
			out_done     <= pop_last && eos_q;
		end
	end

endmodule

### rtl/core/u2a_ctrl.sv
module u2a_ctrl
	import u2a_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  u2a_sts_t sts,
	output u2a_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DRAIN
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && in_valid;
		cmd.step = (state_q == ST_DECODE) && !sts.loop_done;
		cmd.pop  = (state_q == ST_DRAIN) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					if (sts.loop_done) begin
						state_q <= (sts.ecnt == 3'd0) ? ST_IDLE : ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (sts.out_free && sts.last_pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### rtl/core/utf8_to_ascii_replacer.sv
// Flow: an input beat is taken only while the controller is idle; the controller then walks
//   the byte window one decode step per cycle and then drains the result queue one beat per
//   cycle into the output register while m_tready does not hold it off; no new input beat is
//   taken until the last result of the current beat has been popped.
// Reset: arst_n clears the controller, the window fill count and the output valid, and
//   sets the replacement character to '?'; held bytes and queued results are not cleared.
module utf8_to_ascii_replacer
	import u2a_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// configuration: replacement character
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_string
	// output stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [6:0] ascii_byte, [7] zero
	output logic       m_tuser,   // run_last: final result of this input beat
	output logic       m_tlast    // string_done: final result of the string
);

	u2a_cmd_t   cmd;
	u2a_sts_t   sts;
	logic [6:0] out_byte;

	// controller: accept, walk the decode loop, drain the results
	u2a_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: byte window, decoder, result queue, output register
	u2a_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_byte      (s_tdata),
		.in_eos       (s_tlast),
		.cmd          (cmd),
		.sts          (sts),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_byte     (out_byte),
		.out_run_last (m_tuser),
		.out_done     (m_tlast)
	);

	assign m_tdata = {1'b0, out_byte};

endmodule
